// ===== rtl/owvc_pkg.sv =====
// shared types and constants for the odd walk violation check
package owvc_pkg;

   // fixed point weights, 65536 stands for one
   localparam int WEIGHT_W  = 17;
   localparam int MASK_W    = 64;
   localparam int POS_W     = 6;
   localparam int REPAIR_W  = 2;
   localparam int MAX_EDGES = 64;
   localparam int CNT_W     = $clog2(MAX_EDGES + 2);

   localparam logic [WEIGHT_W-1:0] FX_ONE  = WEIGHT_W'(65536);
   localparam logic [WEIGHT_W-1:0] FX_HALF = WEIGHT_W'(32768);

   // parity repair codes
   localparam logic [REPAIR_W-1:0] REPAIR_NONE    = 2'd0;
   localparam logic [REPAIR_W-1:0] REPAIR_UNCROSS = 2'd1;
   localparam logic [REPAIR_W-1:0] REPAIR_CROSS   = 2'd2;

   // running summary of one walk
   typedef struct packed {
      logic [WEIGHT_W-1:0] length;
      logic [WEIGHT_W-1:0] light_w;
      logic [POS_W-1:0]    light_pos;
      logic                light_valid;
      logic [WEIGHT_W-1:0] heavy_w;
      logic [POS_W-1:0]    heavy_pos;
      logic                heavy_valid;
      logic                odd;
      logic [MASK_W-1:0]   mask;
      logic [CNT_W-1:0]    count;
      logic                rejected;
   } walk_sum_type;

   // decided result of one walk
   typedef struct packed {
      logic                found;
      logic [MASK_W-1:0]   mask;
      logic [WEIGHT_W-1:0] length;
      logic [REPAIR_W-1:0] repair;
      logic                too_long;
   } walk_result_type;

endpackage

// ===== rtl/odd_walk_violation_check.sv =====
// odd closed walk violation check, top level
//
// Edge weights of one closed walk arrive on the req_ channel, one edge per
// transfer, in fixed point with 65536 meaning one; req_last marks the final
// edge. One result per walk leaves on the rsp_ channel: whether an odd
// crossing selection shorter than one exists, its crossing mask, the walk
// length before repair, the repair used and a flag for walks with more
// edges than MAX_EDGES.
// Each transfer lands in an input register; from there the edge is folded
// into the walk summary and, on the final edge, the result is registered
// in the output register.
// One edge is taken every cycle unless a final edge waits on a held
// result; the fold in the edge tracker is combinational.
// When rsp_ready is low a finished result waits in the output register;
// non-final edges flow on, but the next final edge and all behind it wait.
// Synchronous reset empties both registers and restarts the walk summary.
module odd_walk_violation_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [owvc_pkg::WEIGHT_W-1:0] req_weight,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [owvc_pkg::MASK_W-1:0]   rsp_cross_mask,
   output logic [owvc_pkg::WEIGHT_W-1:0] rsp_walk_length,
   output logic [owvc_pkg::REPAIR_W-1:0] rsp_repair,
   output logic                          rsp_too_long
);
   import owvc_pkg::*;

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [WEIGHT_W-1:0] s1_weight_ff;
   logic                s1_last_ff;
   logic                advance;
   logic                out_free;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   walk_result_type     rsp_data_ff;
   walk_sum_type        sum_next;
   walk_result_type     result;

   // an edge moves on unless it is final and the output is still held
   always_comb begin
      out_free    = !rsp_valid_ff || rsp_ready;
      advance     = s1_valid_ff && (!s1_last_ff || out_free);
      req_ready   = !s1_valid_ff || advance;
      s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !advance);
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_weight_ff <= req_weight;
         s1_last_ff   <= req_last;
      end
   end

   owvc_edge_track u_track (
      .clock    (clock),
      .reset    (reset),
      .take     (advance),
      .weight   (s1_weight_ff),
      .last     (s1_last_ff),
      .sum_next (sum_next)
   );

   owvc_resolve u_resolve (
      .sum    (sum_next),
      .result (result)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (advance && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_last_ff) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_data_ff.found;
   assign rsp_cross_mask  = rsp_data_ff.mask;
   assign rsp_walk_length = rsp_data_ff.length;
   assign rsp_repair      = rsp_data_ff.repair;
   assign rsp_too_long    = rsp_data_ff.too_long;

endmodule

// ===== rtl/owvc_edge_track.sv =====
// per-walk accumulation of length, crossing mask, parity and repair candidates
module owvc_edge_track (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [owvc_pkg::WEIGHT_W-1:0] weight,
   input  logic                          last,
   output owvc_pkg::walk_sum_type        sum_next
);
   import owvc_pkg::*;

   walk_sum_type        sum_ff;
   walk_sum_type        sum_in;
   walk_sum_type        sum_reset;
   logic [WEIGHT_W-1:0] w_sat;
   logic [WEIGHT_W-1:0] len_add;
   logic [POS_W-1:0]    pos;
   logic                in_range;
   logic                crossing;

   // summary value at the start of a walk
   always_comb begin
      sum_reset             = '0;
      sum_reset.light_w     = FX_ONE;
   end

   // fold one edge into the running summary
   always_comb begin
      w_sat    = (weight > FX_ONE) ? FX_ONE : weight;
      pos      = POS_W'(sum_ff.count);
      in_range = sum_ff.count < CNT_W'(MAX_EDGES);
      crossing = w_sat > FX_HALF;
      len_add  = crossing ? (FX_ONE - w_sat) : w_sat;
      sum_next = sum_ff;
      if (in_range) begin
         sum_next.count = sum_ff.count + CNT_W'(1);
         if (!sum_ff.rejected) begin
            sum_next.length = sum_ff.length + len_add;
            if (crossing) begin
               sum_next.mask[pos] = 1'b1;
               sum_next.odd       = !sum_ff.odd;
               if (w_sat < sum_ff.light_w) begin
                  sum_next.light_w     = w_sat;
                  sum_next.light_pos   = pos;
                  sum_next.light_valid = 1'b1;
               end
            end else if (w_sat > sum_ff.heavy_w) begin
               sum_next.heavy_w     = w_sat;
               sum_next.heavy_pos   = pos;
               sum_next.heavy_valid = 1'b1;
            end
            sum_next.rejected = sum_next.length >= FX_ONE;
         end
      end else begin
         sum_next.count = CNT_W'(MAX_EDGES + 1);
      end
   end

   // restart after the final edge of a walk
   always_comb begin
      sum_in = sum_ff;
      if (take) begin
         sum_in = last ? sum_reset : sum_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= sum_reset;
      end else begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== rtl/owvc_resolve.sv =====
// parity repair and result selection for a finished walk
module owvc_resolve (
   input  owvc_pkg::walk_sum_type    sum,
   output owvc_pkg::walk_result_type result
);
   import owvc_pkg::*;

   logic [WEIGHT_W+1:0] uncross_len;
   logic                too_long;
   logic                usable;
   logic                uncross_ok;
   logic                cross_ok;

   // repaired-length checks, doubled to stay in integers
   always_comb begin
      uncross_len = {2'b00, sum.length} + {1'b0, sum.light_w, 1'b0};
      too_long    = sum.count > CNT_W'(MAX_EDGES);
      usable      = !too_long && !sum.rejected;
      uncross_ok  = sum.light_valid && (uncross_len < {1'b0, FX_ONE, 1'b0});
      cross_ok    = sum.heavy_valid && ({1'b0, sum.length} < {sum.heavy_w, 1'b0});
   end

   // usable walks only: odd parity first, then uncross the lightest, then cross the heaviest
   always_comb begin
      result          = '0;
      result.length   = sum.length;
      result.too_long = too_long;
      priority if (!usable) begin
         result.found = 1'b0;
      end else if (sum.odd) begin
         result.found = 1'b1;
         result.mask  = sum.mask;
      end else if (uncross_ok) begin
         result.found  = 1'b1;
         result.mask   = sum.mask & ~(MASK_W'(1) << sum.light_pos);
         result.repair = REPAIR_UNCROSS;
      end else if (cross_ok) begin
         result.found  = 1'b1;
         result.mask   = sum.mask | (MASK_W'(1) << sum.heavy_pos);
         result.repair = REPAIR_CROSS;
      end else begin
         result.repair = REPAIR_NONE;
      end
   end

endmodule
